// ===== src/utf8dp_pkg.sv =====
package utf8dp_pkg;

    // Widths fixed by the item formats.
    localparam int unsigned CP_W      = 21;
    localparam int unsigned POS_OUT_W = 24;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 72;

    // Default width of the internal row and column counters.
    localparam int unsigned POSITION_WIDTH_DEF = 24;

    // Item kinds carried on s_tuser.
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Lead and continuation byte patterns.
    localparam logic [BYTE_W-1:0] ASCII_MASK = 8'h80;
    localparam logic [BYTE_W-1:0] ASCII_PAT  = 8'h00;
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_PAT   = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_PAT  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_PAT  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_PAT  = 8'hF0;

    // Special code points.
    localparam logic [CP_W-1:0] CP_BOM = 21'h00FEFF;
    localparam logic [CP_W-1:0] CP_CR  = 21'h00000D;
    localparam logic [CP_W-1:0] CP_LF  = 21'h00000A;

    typedef logic [POS_OUT_W-1:0] pos_out_t;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        pos_out_t        row;
        pos_out_t        column;
        logic            ended;
    } result_t;

endpackage

// ===== src/utf8dp_in_stage.sv =====
module utf8dp_in_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  utf8dp_pkg::item_t    s_item,
    input  logic                 downstream_ready,
    output logic                 item_valid,
    output utf8dp_pkg::item_t    item
);

    logic               valid_reg;
    logic               valid_next;
    utf8dp_pkg::item_t  item_reg;

    // The held request leaves whenever the core can step, so a new one may
    // enter in the same cycle.
    assign s_ready = !valid_reg || downstream_ready;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (downstream_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== src/utf8dp_core.sv =====
module utf8dp_core #(
    parameter int unsigned POSITION_WIDTH = utf8dp_pkg::POSITION_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step_en,
    input  utf8dp_pkg::item_t     item,
    output logic                  res_valid,
    output utf8dp_pkg::result_t   result
);

    localparam logic [POSITION_WIDTH-1:0] POS_ONE = {{(POSITION_WIDTH-1){1'b0}}, 1'b1};

    logic [1:0]                      bytes_left_reg, bytes_left_next;
    logic [utf8dp_pkg::CP_W-1:0]     partial_reg, partial_next;
    logic                            at_start_reg, at_start_next;
    logic                            ended_reg, ended_next;
    logic [POSITION_WIDTH-1:0]       row_reg, row_next;
    logic [POSITION_WIDTH-1:0]       column_reg, column_next;

    logic [utf8dp_pkg::BYTE_W-1:0]   b;
    logic                            do_end;
    logic                            do_char;
    logic [utf8dp_pkg::CP_W-1:0]     char_cp;
    logic [utf8dp_pkg::CP_W-1:0]     shifted_cp;

    assign b          = item.data_byte;
    assign shifted_cp = {partial_reg[utf8dp_pkg::CP_W-7:0], b[5:0]};

    always_comb begin
        bytes_left_next = bytes_left_reg;
        partial_next    = partial_reg;
        at_start_next   = at_start_reg;
        ended_next      = ended_reg;
        row_next        = row_reg;
        column_next     = column_reg;
        do_end          = 1'b0;
        do_char         = 1'b0;
        char_cp         = {{(utf8dp_pkg::CP_W-utf8dp_pkg::BYTE_W){1'b0}}, b};
        res_valid       = 1'b0;
        result          = '0;

        if (ended_reg) begin
            // Everything after the final result is dropped.
        end else if (item.kind == utf8dp_pkg::KIND_END) begin
            do_end = 1'b1;
        end else if (bytes_left_reg != 2'd0) begin
            if ((b & utf8dp_pkg::CONT_MASK) != utf8dp_pkg::CONT_PAT) begin
                do_end = 1'b1;
            end else begin
                partial_next    = shifted_cp;
                bytes_left_next = bytes_left_reg - 2'd1;
                if (bytes_left_reg == 2'd1) begin
                    do_char = 1'b1;
                    char_cp = shifted_cp;
                end
            end
        end else if ((b & utf8dp_pkg::ASCII_MASK) == utf8dp_pkg::ASCII_PAT) begin
            do_char = 1'b1;
        end else if ((b & utf8dp_pkg::LEAD2_MASK) == utf8dp_pkg::LEAD2_PAT) begin
            partial_next    = {16'd0, b[4:0]};
            bytes_left_next = 2'd1;
        end else if ((b & utf8dp_pkg::LEAD3_MASK) == utf8dp_pkg::LEAD3_PAT) begin
            partial_next    = {17'd0, b[3:0]};
            bytes_left_next = 2'd2;
        end else if ((b & utf8dp_pkg::LEAD4_MASK) == utf8dp_pkg::LEAD4_PAT) begin
            partial_next    = {18'd0, b[2:0]};
            bytes_left_next = 2'd3;
        end else begin
            do_end = 1'b1;
        end

        if (do_end) begin
            ended_next        = 1'b1;
            bytes_left_next   = 2'd0;
            partial_next      = '0;
            res_valid         = 1'b1;
            result.code_point = '0;
            result.row        = utf8dp_pkg::pos_out_t'(row_reg);
            result.column     = utf8dp_pkg::pos_out_t'(column_reg);
            result.ended      = 1'b1;
        end else if (do_char) begin
            at_start_next = 1'b0;
            // A byte-order mark as the first character is swallowed.
            if (!(at_start_reg && char_cp == utf8dp_pkg::CP_BOM)) begin
                if (char_cp == utf8dp_pkg::CP_CR || char_cp == utf8dp_pkg::CP_LF) begin
                    if (row_reg != '1) begin
                        row_next = row_reg + POS_ONE;
                    end
                    column_next = '0;
                end else if (column_reg != '1) begin
                    column_next = column_reg + POS_ONE;
                end
                res_valid         = 1'b1;
                result.code_point = char_cp;
                result.row        = utf8dp_pkg::pos_out_t'(row_next);
                result.column     = utf8dp_pkg::pos_out_t'(column_next);
                result.ended      = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_left_reg <= 2'd0;
            partial_reg    <= '0;
            at_start_reg   <= 1'b1;
            ended_reg      <= 1'b0;
            row_reg        <= '0;
            column_reg     <= '0;
        end else if (step_en) begin
            bytes_left_reg <= bytes_left_next;
            partial_reg    <= partial_next;
            at_start_reg   <= at_start_next;
            ended_reg      <= ended_next;
            row_reg        <= row_next;
            column_reg     <= column_next;
        end
    end

endmodule

// ===== src/utf8dp_out_stage.sv =====
module utf8dp_out_stage (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  logic                  res_valid,
    input  utf8dp_pkg::result_t   result,
    output logic                  can_load,
    output logic                  m_valid,
    input  logic                  m_ready,
    output utf8dp_pkg::result_t   m_result
);

    logic                 valid_reg;
    logic                 valid_next;
    utf8dp_pkg::result_t  result_reg;

    assign can_load = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = res_valid;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (load && res_valid) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

// ===== src/utf8_decoder_with_position.sv =====
// UTF-8 decoder with row and column tracking. Bytes enter on the s_ stream
// (s_tuser low) and each finished code point leaves on the m_ stream with the
// row and column that follow it; CR and LF each start a new row, every other
// character moves one column, and both counters stop at their maximum. A
// byte-order mark as the very first character is dropped. An end-of-input
// request (s_tuser high), a bad lead byte or a bad continuation byte produces
// one final result with m_tlast high and code point 0, after which every
// request is taken and discarded until reset. The block takes one byte per
// clock cycle when the output is not stalled; the last byte of a character is
// captured in the input register, and its result is loaded into the result
// register when the core steps, and is presented from there. s_tready follows
// m_tready combinationally through the one-deep input register. POSITION_WIDTH
// sets the counter width; the output fields carry the low 24 bits of the
// counters.
module utf8_decoder_with_position #(
    parameter int unsigned POSITION_WIDTH = utf8dp_pkg::POSITION_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [utf8dp_pkg::S_TDATA_W-1:0]  s_tdata,  // [7:0] data_byte
    input  logic                              s_tuser,  // [0] kind: 1 = end of input
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [20:0] code_point, [44:21] row, [68:45] column, [71:69] zero
    output logic [utf8dp_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                              m_tlast   // ended
);

    utf8dp_pkg::item_t    s_item;
    utf8dp_pkg::item_t    item;
    logic                 item_valid;
    logic                 can_load;
    logic                 step_en;
    logic                 res_valid;
    utf8dp_pkg::result_t  result;
    utf8dp_pkg::result_t  m_result;

    assign s_item.kind      = s_tuser;
    assign s_item.data_byte = s_tdata;

    // The core steps exactly when a request is held and the result register
    // is free or being emptied this cycle.
    assign step_en = item_valid && can_load;

    utf8dp_in_stage u_in_stage (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_tvalid),
        .s_ready          (s_tready),
        .s_item           (s_item),
        .downstream_ready (can_load),
        .item_valid       (item_valid),
        .item             (item)
    );

    utf8dp_core #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (step_en),
        .item      (item),
        .res_valid (res_valid),
        .result    (result)
    );

    utf8dp_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (step_en),
        .res_valid (res_valid),
        .result    (result),
        .can_load  (can_load),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_result  (m_result)
    );

    assign m_tdata = {3'b000, m_result.column, m_result.row, m_result.code_point};
    assign m_tlast = m_result.ended;

endmodule

// ===== src/utf8dp_checker.sv =====
module utf8dp_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [utf8dp_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                              s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [utf8dp_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                              m_tlast
);

    logic                           seen_end_reg;
    logic [utf8dp_pkg::CP_W-1:0]    cp;

    assign cp = m_tdata[20:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_end_reg <= 1'b0;
        end else if (m_tvalid && m_tready && m_tlast) begin
            seen_end_reg <= 1'b1;
        end
    end

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // A waiting request holds.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("request changed while waiting");

    a_end_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> cp == '0)
        else $error("final result carries a nonzero code point");

    a_silent_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_end_reg |-> !m_tvalid)
        else $error("result after the final result");

    a_newline_col: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast && (cp == utf8dp_pkg::CP_CR || cp == utf8dp_pkg::CP_LF)
        |-> m_tdata[68:45] == '0)
        else $error("line break did not clear the column");

endmodule

bind utf8_decoder_with_position utf8dp_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
